// ===== hdl/spt_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted priority table package
// Shared word types and status codes for the sorted priority table core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spt_pkg;

  // Default table depth and stored priority width.
  localparam int DEPTH_DEF     = 6;
  localparam int PRIO_BITS_DEF = 16;

  // Status reported with every slot of a request.
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_DELETED  = 3'd2,
    ST_MISSED   = 3'd3,
    ST_FULL     = 3'd4,
    ST_SAME     = 3'd5
  } status_t;

  // Request word as it arrives on the input port.
  typedef struct packed {
    logic [15:0] priority_req;
    logic [7:0]  value;
  } in_word_t;

  // One slot of the table report.
  typedef struct packed {
    logic [2:0] slot_index;
    logic [7:0] slot_value;
    logic       last_slot;
    status_t    status;
  } out_word_t;

  // Classified request as it waits between the front and the back end.
  typedef struct packed {
    logic [15:0] prio;
    logic [7:0]  value;
    logic        is_del;
  } item_t;

  // Handshake between the request queue and its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hdl/spt_front.sv =====
// ---------------------------------------------------------------------------
// Sorted priority table front end
// Takes request words, masks the priority and marks deletes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spt_front #(
  parameter int PRIO_BITS = spt_pkg::PRIO_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire spt_pkg::in_word_t in_word,
  input  wire spt_pkg::q_stat_t  q_stat,
  output logic                   push,
  output spt_pkg::item_t         push_item
);

  // Priority bits that the table keeps.
  localparam logic [15:0] PRIO_MASK =
    (PRIO_BITS >= 16) ? 16'hFFFF : 16'((1 << PRIO_BITS) - 1);

  logic           hold_r, hold_nxt;
  spt_pkg::item_t item_r;
  logic           accept;

  // A held word leaves as soon as the queue has room.
  assign push      = hold_r && !q_stat.full;
  assign busy      = hold_r && q_stat.full;
  assign accept    = start && !busy;
  assign push_item = item_r;
  assign hold_nxt  = accept || (hold_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  // Classify the word as it is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.prio   <= in_word.priority_req & PRIO_MASK;
      item_r.value  <= in_word.value;
      item_r.is_del <= ((in_word.priority_req & PRIO_MASK) == 16'd0);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spt_queue.sv =====
// ---------------------------------------------------------------------------
// Sorted priority table request queue
// Two-entry queue that lets the front and the back end stall separately.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spt_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire spt_pkg::item_t push_item,
  input  wire logic           pop,
  output spt_pkg::item_t      pop_item,
  output spt_pkg::q_stat_t    q_stat
);

  spt_pkg::item_t ent_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign pop_item     = ent_r[rd_ptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spt_back.sv =====
// ---------------------------------------------------------------------------
// Sorted priority table back end
// Row of table cells, the request sequencer and the slot readout shifter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spt_back #(
  parameter int DEPTH     = spt_pkg::DEPTH_DEF,
  parameter int PRIO_BITS = spt_pkg::PRIO_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire spt_pkg::q_stat_t q_stat,
  input  wire spt_pkg::item_t   pop_item,
  output logic                  pop,
  output logic                  out_valid,
  output spt_pkg::out_word_t    out_word
);

  localparam int IW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_UPD,
    S_EMIT
  } state_t;

  state_t                state_r;
  spt_pkg::item_t        cur_r;
  logic [DEPTH-1:0]      eqv_r, eqp_r, gtp_r;
  spt_pkg::status_t      status_r, status_nxt;
  logic [IW-1:0]         cnt_r;
  logic [2:0]            slot_r;
  logic [7:0]            emit_r [DEPTH];

  // Table cells, kept sorted by falling priority; empty cells hold zero.
  logic [PRIO_BITS-1:0]  prio_r   [DEPTH];
  logic [7:0]            val_r    [DEPTH];
  logic [DEPTH-1:0]      vld_r;
  logic [PRIO_BITS-1:0]  prio_nxt [DEPTH];
  logic [7:0]            val_nxt  [DEPTH];
  logic [DEPTH-1:0]      vld_nxt;

  logic [PRIO_BITS-1:0]  cur_prio;
  logic [DEPTH-1:0]      eqv_c, eqp_c, gtp_c;
  logic [DEPTH-1:0]      fv, ge, ins;
  logic                  hv_any, hp_any;
  logic                  do_drop, do_set, do_ins;
  logic                  last_c;
  logic [7:0]            base_val [DEPTH];
  logic [PRIO_BITS-1:0]  up_prio  [DEPTH];
  logic [7:0]            up_val   [DEPTH];
  logic [PRIO_BITS-1:0]  dn_prio  [DEPTH];
  logic [7:0]            dn_val   [DEPTH];
  logic [DEPTH-1:0]      up_vld, dn_vld;

  assign cur_prio = PRIO_BITS'(cur_r.prio);
  assign last_c   = (cnt_r == IW'(DEPTH - 1));
  assign pop      = ((state_r == S_IDLE) || ((state_r == S_EMIT) && last_c)) &&
                    !q_stat.empty;

  // Every cell compares its own entry with the request.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      eqv_c[i] = vld_r[i] && (val_r[i] == cur_r.value);
      eqp_c[i] = vld_r[i] && (prio_r[i] == cur_prio);
      gtp_c[i] = vld_r[i] && (prio_r[i] > cur_prio);
    end
  end

  // Pick the operation from the registered match vectors.
  always_comb begin
    fv     = eqv_r & (~eqv_r + DEPTH'(1));
    hv_any = |eqv_r;
    hp_any = |eqp_r;
    ge     = hv_any ? ~(fv - DEPTH'(1)) : '0;
    for (int i = 0; i < DEPTH; i++) begin
      ins[i] = !gtp_r[i] && ((i == 0) || gtp_r[(i == 0) ? 0 : i - 1]);
    end
    do_drop    = 1'b0;
    do_set     = 1'b0;
    do_ins     = 1'b0;
    status_nxt = spt_pkg::ST_MISSED;
    if (cur_r.is_del) begin
      do_drop    = hv_any;
      status_nxt = hv_any ? spt_pkg::ST_DELETED : spt_pkg::ST_MISSED;
    end else if (hp_any) begin
      if (fv == eqp_r) begin
        status_nxt = spt_pkg::ST_SAME;
      end else begin
        do_set     = 1'b1;
        do_drop    = hv_any;
        status_nxt = spt_pkg::ST_REPLACED;
      end
    end else if (!vld_r[DEPTH-1]) begin
      do_ins     = 1'b1;
      status_nxt = spt_pkg::ST_INSERTED;
    end else begin
      status_nxt = spt_pkg::ST_FULL;
    end
  end

  // Neighbor views of the row for shifting up and down.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      base_val[i] = (do_set && eqp_r[i]) ? cur_r.value : val_r[i];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      up_prio[i]   = prio_r[i+1];
      up_val[i]    = base_val[i+1];
      up_vld[i]    = vld_r[i+1];
      dn_prio[i+1] = prio_r[i];
      dn_val[i+1]  = base_val[i];
      dn_vld[i+1]  = vld_r[i];
    end
    up_prio[DEPTH-1] = '0;
    up_val[DEPTH-1]  = '0;
    up_vld[DEPTH-1]  = 1'b0;
    dn_prio[0]       = '0;
    dn_val[0]        = '0;
    dn_vld[0]        = 1'b0;
  end

  // Next contents of each cell.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      prio_nxt[i] = prio_r[i];
      val_nxt[i]  = base_val[i];
      vld_nxt[i]  = vld_r[i];
      if (do_drop && ge[i]) begin
        prio_nxt[i] = up_prio[i];
        val_nxt[i]  = up_val[i];
        vld_nxt[i]  = up_vld[i];
      end else if (do_ins && ins[i]) begin
        prio_nxt[i] = cur_prio;
        val_nxt[i]  = cur_r.value;
        vld_nxt[i]  = 1'b1;
      end else if (do_ins && !gtp_r[i]) begin
        prio_nxt[i] = dn_prio[i];
        val_nxt[i]  = dn_val[i];
        vld_nxt[i]  = dn_vld[i];
      end
    end
  end

  // Cell row, written once per request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        prio_r[i] <= '0;
        val_r[i]  <= '0;
      end
    end else if (state_r == S_UPD) begin
      vld_r <= vld_nxt;
      for (int i = 0; i < DEPTH; i++) begin
        prio_r[i] <= prio_nxt[i];
        val_r[i]  <= val_nxt[i];
      end
    end
  end

  // Readout shifter: loaded with the new table, slot 0 leaves first.
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      for (int i = 0; i < DEPTH; i++) begin
        emit_r[i] <= val_nxt[i];
      end
    end else if (state_r == S_EMIT) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        emit_r[i] <= emit_r[i+1];
      end
      emit_r[DEPTH-1] <= '0;
    end
  end

  // Sequencer: search, update, then one slot word per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      slot_r   <= '0;
      status_r <= spt_pkg::ST_INSERTED;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            cur_r   <= pop_item;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          eqv_r   <= eqv_c;
          eqp_r   <= eqp_c;
          gtp_r   <= gtp_c;
          state_r <= S_UPD;
        end
        S_UPD: begin
          status_r <= status_nxt;
          cnt_r    <= '0;
          slot_r   <= '0;
          state_r  <= S_EMIT;
        end
        S_EMIT: begin
          cnt_r  <= cnt_r + IW'(1);
          slot_r <= slot_r + 3'd1;
          if (last_c) begin
            if (!q_stat.empty) begin
              cur_r   <= pop_item;
              state_r <= S_SRCH;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result word straight from registers.
  assign out_valid           = (state_r == S_EMIT);
  assign out_word.slot_index = slot_r;
  assign out_word.slot_value = emit_r[0];
  assign out_word.last_slot  = last_c;
  assign out_word.status     = status_r;

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_table_core.sv =====
// ---------------------------------------------------------------------------
// Sorted priority table core
// Sorted (priority, value) table with insert, replace and delete requests.
// ---------------------------------------------------------------------------
// A request word is taken at a rising edge with start high and busy low.
// Each request produces DEPTH result words, slot 0 first, one per cycle
// with out_valid high, all carrying the request's status; results cannot be
// held off, so the receiver must take every word as it appears. The back end
// handles each request in a search step over the cell row, an update step
// and then serial slot readout, and this readout sets the sustained rate.
// A holding register and a two-entry queue let further requests be taken
// while a report is still going out; busy rises only when both are full.
// The table is empty after reset with no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_table_core #(
  parameter int DEPTH     = spt_pkg::DEPTH_DEF,
  parameter int PRIO_BITS = spt_pkg::PRIO_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire spt_pkg::in_word_t  in_word,
  output logic                    out_valid,
  output spt_pkg::out_word_t      out_word
);

  spt_pkg::q_stat_t q_stat;
  spt_pkg::item_t   push_item, pop_item;
  logic             push, pop;

  // Accept and classify requests.
  spt_front #(
    .PRIO_BITS (PRIO_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue.
  spt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // Table update and readout.
  spt_back #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== hdl/spt_checker.sv =====
// ---------------------------------------------------------------------------
// Sorted priority table checker
// Port-level checks on the shape of each table report.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire spt_pkg::out_word_t out_word
);

  // No report word right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

  // A report starts at slot 0.
  a_first_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> (out_word.slot_index == 3'd0))
    else $error("report does not start at slot 0");

  // Slots of one report follow back to back in order.
  a_next_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last_slot) |=>
      (out_valid && (out_word.slot_index == $past(out_word.slot_index) + 3'd1)))
    else $error("slot words not consecutive");

  // Status holds across one report.
  a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last_slot) |=> $stable(out_word.status))
    else $error("status changed within a report");

  // Reports never follow back to back: out_valid drops after the last slot.
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last_slot) |=> !out_valid)
    else $error("report follows the previous one without a gap");

endmodule

bind sorted_priority_table_core spt_checker u_spt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_word  (out_word)
);

`default_nettype wire

// ===== tb/sorted_priority_table_core_test.sv =====
// ---------------------------------------------------------------------------
// Sorted priority table core testbench
// Sends insert, replace and delete requests to the core and checks every
// slot word of each table report against a behavioral table kept in step
// with the requests. A directed run covers the corner cases, and a random
// run covers the rest, with random sender gaps and occasional drain pauses.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_table_core_test;

  localparam int DEPTH       = spt_pkg::DEPTH_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 4 * (DEPTH + 2);
  localparam int CALM_TAIL   = 50;
  localparam int RANDOM_REQS = 425;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  spt_pkg::in_word_t  in_word = '0;
  logic               busy;
  logic               out_valid;
  spt_pkg::out_word_t out_word;

  // Behavioral copy of the table.
  logic [15:0] tbl_prio [DEPTH] = '{default: '0};
  logic [7:0]  tbl_val  [DEPTH] = '{default: '0};
  int          tbl_count = 0;

  // Slot words still to come, and requests still to be sent.
  spt_pkg::out_word_t slot_words_q [$];
  spt_pkg::in_word_t  request_q [$];
  bit                 request_drain_q [$];

  spt_pkg::out_word_t want_word;
  int                 n_errors    = 0;
  int                 gap_left    = 0;
  int                 idle_cycles = 0;

  sorted_priority_table_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always #4 clk = ~clk;

  // Remove one entry and close the gap toward slot 0.
  function automatic void remove_slot(int k);
    for (int i = k; i < DEPTH - 1; i++) begin
      tbl_prio[i] = tbl_prio[i + 1];
      tbl_val[i]  = tbl_val[i + 1];
    end
    tbl_prio[DEPTH - 1] = '0;
    tbl_val[DEPTH - 1]  = '0;
    tbl_count--;
  endfunction

  // Apply one request to the table and queue the report it produces.
  function automatic void predict_table_report(spt_pkg::in_word_t w);
    int                 val_at;
    int                 prio_at;
    int                 pos;
    spt_pkg::status_t   st;
    spt_pkg::out_word_t r;
    val_at  = DEPTH;
    prio_at = DEPTH;
    // Walk downward so that the first matching entry wins.
    for (int i = tbl_count - 1; i >= 0; i--) begin
      if (tbl_val[i] == w.value) val_at = i;
      if (tbl_prio[i] == w.priority_req) prio_at = i;
    end
    if (w.priority_req == '0) begin
      if (val_at < DEPTH) begin
        remove_slot(val_at);
        st = spt_pkg::ST_DELETED;
      end else begin
        st = spt_pkg::ST_MISSED;
      end
    end else if (prio_at < DEPTH) begin
      if (val_at == prio_at) begin
        st = spt_pkg::ST_SAME;
      end else begin
        tbl_val[prio_at] = w.value;
        if (val_at < DEPTH) remove_slot(val_at);
        st = spt_pkg::ST_REPLACED;
      end
    end else if (tbl_count < DEPTH) begin
      pos = 0;
      while (pos < tbl_count && tbl_prio[pos] > w.priority_req) pos++;
      for (int i = DEPTH - 1; i > pos; i--) begin
        tbl_prio[i] = tbl_prio[i - 1];
        tbl_val[i]  = tbl_val[i - 1];
      end
      tbl_prio[pos] = w.priority_req;
      tbl_val[pos]  = w.value;
      tbl_count++;
      st = spt_pkg::ST_INSERTED;
    end else begin
      st = spt_pkg::ST_FULL;
    end
    // The whole table is reported, slot 0 first.
    for (int k = 0; k < DEPTH; k++) begin
      r.slot_index = 3'(k);
      r.slot_value = tbl_val[k];
      r.last_slot  = (k == DEPTH - 1);
      r.status     = st;
      slot_words_q.push_back(r);
    end
  endfunction

  function automatic void add_request(logic [15:0] prio, logic [7:0] val, bit drain);
    spt_pkg::in_word_t w;
    w.priority_req = prio;
    w.value        = val;
    request_q.push_back(w);
    request_drain_q.push_back(drain);
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Driver: a word is taken when start is high and busy is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_table_report(in_word);
        if (request_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 19);
        end
      end
      // A pending word is held until it is taken.
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (request_q.size() == 0) begin
          start <= 1'b0;
        end else if (request_drain_q[0] && slot_words_q.size() != 0) begin
          start <= 1'b0;
        end else begin
          in_word <= request_q.pop_front();
          void'(request_drain_q.pop_front());
          start   <= 1'b1;
        end
      end
    end
  end

  // Monitor: every slot word is compared with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (slot_words_q.size() == 0) begin
        $display("%0t: unexpected slot word, expected none, actual %h", $time, out_word);
        n_errors++;
      end else begin
        want_word = slot_words_q.pop_front();
        check_field("slot_index", want_word.slot_index, out_word.slot_index);
        check_field("slot_value", want_word.slot_value, out_word.slot_value);
        check_field("last_slot", want_word.last_slot, out_word.last_slot);
        check_field("status", want_word.status, out_word.status);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [15:0] p;
    logic [7:0]  v;

    // Delete on an empty table: empty slots never match, even value 0.
    add_request(16'h0000, 8'h00, 1'b0);
    // Build a table with a repeated value.
    add_request(16'hFFFF, 8'hFF, 1'b0);
    add_request(16'h0001, 8'h00, 1'b0);
    add_request(16'h8000, 8'hAA, 1'b0);
    add_request(16'h4000, 8'hAA, 1'b0);
    // Identical pair, then an existing pair whose value sits first elsewhere.
    add_request(16'h8000, 8'hAA, 1'b0);
    add_request(16'h4000, 8'hAA, 1'b0);
    // Replace removing another holder, then replace with a fresh value.
    add_request(16'h4000, 8'hFF, 1'b0);
    add_request(16'h0001, 8'h55, 1'b0);
    // Fill the table; the first of these waits for the table to drain.
    add_request(16'h5555, 8'h55, 1'b1);
    add_request(16'hAAAA, 8'h00, 1'b0);
    add_request(16'h2AAA, 8'h11, 1'b0);
    add_request(16'h0002, 8'h22, 1'b0);
    // New priority on a full table, then a replace while full.
    add_request(16'h7FFF, 8'h33, 1'b0);
    add_request(16'h0002, 8'h44, 1'b0);
    // Delete both copies of a repeated value, then miss; delete value 00, insert two.
    add_request(16'h0000, 8'h55, 1'b0);
    add_request(16'h0000, 8'h55, 1'b0);
    add_request(16'h0000, 8'h55, 1'b0);
    add_request(16'h0000, 8'h00, 1'b0);
    add_request(16'hFFFF, 8'h01, 1'b0);
    add_request(16'hFFFE, 8'h80, 1'b0);
    // Empty the table again.
    add_request(16'h0000, 8'hFF, 1'b0);
    add_request(16'h0000, 8'h11, 1'b0);
    add_request(16'h0000, 8'h44, 1'b0);
    add_request(16'h0000, 8'h01, 1'b0);
    add_request(16'h0000, 8'h80, 1'b0);

    // Random requests over small pools so that hits and a full table are common.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if ($urandom_range(0, 9) < 7) v = 8'($urandom_range(0, 7));
      else v = 8'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2:    p = 16'h0000;
        3, 4, 5, 6: p = 16'($urandom_range(1, 10));
        7:          p = $urandom_range(0, 1) ? 16'hFFFF : 16'h8000;
        default:    p = 16'($urandom_range(1, 65535));
      endcase
      add_request(p, v, $urandom_range(0, 39) == 0);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || start || slot_words_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    // Every expected slot word must have arrived by now.
    if (slot_words_q.size() != 0) begin
      $display("%0t: missing slot words, expected %0d more, actual 0", $time,
               slot_words_q.size());
      n_errors++;
    end

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/spt_pkg.sv
hdl/spt_front.sv
hdl/spt_queue.sv
hdl/spt_back.sv
hdl/sorted_priority_table_core.sv
hdl/spt_checker.sv
tb/sorted_priority_table_core_test.sv
